>>> hdl/ddr_pkg.sv
// Package for the differential drive ramp core.
// Holds field widths, request and register codes, reciprocal constants and the
// speed clamp. No dependencies.
package ddr_pkg;

  localparam int SPEED_W  = 8;
  localparam int REQ_W    = 3;
  localparam int RUDDER_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 24;

  localparam logic [REQ_W-1:0] REQ_STOP      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STEER     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FORWARD   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REVERSE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SPIN_R    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SPIN_L    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_CAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TURN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED = 3'd4;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 8'd127;
  localparam logic [SPEED_W-1:0] SLOW_CAP_RST   = 8'd20;
  localparam logic [SPEED_W-1:0] TURN_SPEED_RST = 8'd80;
  localparam logic [SPEED_W-1:0] LOW_TURN_RST   = 8'd40;
  localparam logic [SPEED_W-1:0] STOP_SPEED_RST = 8'd0;

  localparam logic [RUDDER_W-1:0] RUDDER_LO = 8'd117;
  localparam logic [RUDDER_W-1:0] RUDDER_HI = 8'd137;
  localparam logic [SPEED_W-1:0]  RAMP_STEP = 8'd4;

  // floor(x/d) as (x * ceil(2^K/d)) >> K, exact over the rudder range
  localparam int RECIP_K = 21;
  localparam longint RECIP_117 = ((64'd1 << RECIP_K) + 64'd116) / 64'd117;
  localparam longint RECIP_118 = ((64'd1 << RECIP_K) + 64'd117) / 64'd118;

  localparam int LPROD_W = 29;
  localparam int RPROD_W = 30;
  localparam logic [LPROD_W-1:0] L_MUL  = LPROD_W'(64'd107 * RECIP_117);
  localparam logic [RPROD_W-1:0] R_MUL  = RPROD_W'(64'd107 * RECIP_118);
  localparam logic [RPROD_W-1:0] R_BASE = RPROD_W'(64'd29645 * RECIP_118);

  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic [SPEED_W-1:0] up,
    input logic [SPEED_W-1:0] lo,
    input logic [SPEED_W-1:0] x
  );
    logic [SPEED_W-1:0] res;
    if (up <= x) begin
      res = up;
    end else if (lo >= x) begin
      res = lo;
    end else begin
      res = x;
    end
    return res;
  endfunction

endpackage

>>> hdl/differential_drive_ramp_core.sv
// Differential drive command decoder with soft-start ramp, top level.
// Depends on ddr_pkg for widths, codes, reciprocal constants and the clamp.
//
// Channel | Direction | Ports                         | Contents
// in_     | slave     | in_tvalid/tready/tdata/tuser  | rudder; req_type, slow_mode
// out_    | master    | out_tvalid/tready/tdata       | speeds and directions
// cfg_    | slave     | cfg_valid/ready/index/data    | speed register writes
//
// One transaction per cycle sustained while the output is not stalled; an item passes
// the input register and then the output register, with the steering
// math (two constant multiplies, shift, add, clamp) between them.
// Ramp and direction state update as an item moves to the output register.
// Reset is synchronous, active low; config, state and valid registers reset.
// An output stall holds the output register and then the input register.
module differential_drive_ramp_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ddr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] rudder
  input  logic [ddr_pkg::IN_TUSER_W-1:0]    in_tuser,   // [2:0] req_type, [3] slow_mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ddr_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [7:0] left_speed,
                                                        // [15:8] right_speed,
                                                        // [16] left_reverse,
                                                        // [17] right_reverse, [23:18] 0
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddr_pkg::SPEED_W-1:0]       cfg_data
);
  import ddr_pkg::*;

  logic [SPEED_W-1:0] max_speed_r, slow_cap_r, turn_speed_r, low_turn_r, stop_speed_r;

  logic                s1_valid_r;
  logic [REQ_W-1:0]    s1_req_r;
  logic [RUDDER_W-1:0] s1_rudder_r;
  logic                s1_slow_r;

  logic [SPEED_W-1:0]  ramp_r, ramp_nxt;
  logic                ldir_r, ldir_nxt, rdir_r, rdir_nxt;

  logic                out_valid_r;
  logic [SPEED_W-1:0]  lspd_r, lspd_nxt, rspd_r, rspd_nxt;

  logic                adv;

  logic [LPROD_W-1:0]  lprod;
  logic [RPROD_W-1:0]  rprod;
  logic [SPEED_W-1:0]  q_l;
  logic [SPEED_W:0]    lraw;
  logic [SPEED_W-1:0]  lsat, rraw;
  logic [SPEED_W-1:0]  limit, cap_out;
  logic [SPEED_W:0]    ramp_sum;
  logic [SPEED_W-1:0]  ramp_inc;
  logic [SPEED_W-1:0]  ramp_out;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= MAX_SPEED_RST;
      slow_cap_r   <= SLOW_CAP_RST;
      turn_speed_r <= TURN_SPEED_RST;
      low_turn_r   <= LOW_TURN_RST;
      stop_speed_r <= STOP_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_SPEED:  max_speed_r  <= cfg_data;
        REG_SLOW_CAP:   slow_cap_r   <= cfg_data;
        REG_TURN_SPEED: turn_speed_r <= cfg_data;
        REG_LOW_TURN:   low_turn_r   <= cfg_data;
        REG_STOP_SPEED: stop_speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r    <= in_tuser[REQ_W-1:0];
      s1_slow_r   <= in_tuser[REQ_W];
      s1_rudder_r <= in_tdata[RUDDER_W-1:0];
    end
  end

  // steering map
  always_comb begin
    lprod = LPROD_W'(s1_rudder_r) * L_MUL;
    rprod = R_BASE - RPROD_W'(s1_rudder_r) * R_MUL;
    q_l   = lprod[LPROD_W-1 -: SPEED_W];
    lraw  = {1'b0, slow_cap_r} + {1'b0, q_l};
    lsat  = lraw[SPEED_W] ? {SPEED_W{1'b1}} : lraw[SPEED_W-1:0];
    rraw  = rprod[RECIP_K +: SPEED_W];
  end

  // ramp
  always_comb begin
    limit   = max_speed_r;
    cap_out = max_speed_r;
    unique case (s1_req_r)
      REQ_FORWARD, REQ_REVERSE: begin
        limit   = s1_slow_r ? slow_cap_r : max_speed_r;
        cap_out = limit;
      end
      REQ_SPIN_R, REQ_SPIN_L: begin
        limit   = s1_slow_r ? slow_cap_r : turn_speed_r;
        cap_out = s1_slow_r ? low_turn_r : turn_speed_r;
      end
      default: ;
    endcase
    ramp_sum = {1'b0, ramp_r} + {1'b0, RAMP_STEP};
    ramp_inc = ramp_sum[SPEED_W] ? {SPEED_W{1'b1}} : ramp_sum[SPEED_W-1:0];
    ramp_out = (ramp_r >= limit) ? cap_out : ramp_inc;
  end

  always_comb begin
    ramp_nxt = ramp_r;
    ldir_nxt = ldir_r;
    rdir_nxt = rdir_r;
    lspd_nxt = stop_speed_r;
    rspd_nxt = stop_speed_r;
    unique case (s1_req_r)
      REQ_STEER: begin
        ldir_nxt = 1'b0;
        rdir_nxt = 1'b0;
        if (s1_slow_r) begin
          lspd_nxt = clamp_speed(max_speed_r, slow_cap_r, slow_cap_r);
          rspd_nxt = lspd_nxt;
        end else if (s1_rudder_r > RUDDER_LO && s1_rudder_r < RUDDER_HI) begin
          lspd_nxt = clamp_speed(max_speed_r, slow_cap_r, max_speed_r);
          rspd_nxt = lspd_nxt;
        end else if (s1_rudder_r <= RUDDER_LO) begin
          lspd_nxt = clamp_speed(max_speed_r, slow_cap_r, lsat);
          rspd_nxt = clamp_speed(max_speed_r, slow_cap_r, max_speed_r);
        end else begin
          lspd_nxt = clamp_speed(max_speed_r, slow_cap_r, max_speed_r);
          rspd_nxt = clamp_speed(max_speed_r, slow_cap_r, rraw);
        end
      end
      REQ_FORWARD, REQ_REVERSE: begin
        ldir_nxt = (s1_req_r == REQ_REVERSE);
        rdir_nxt = ldir_nxt;
        ramp_nxt = (ramp_r >= limit) ? ramp_r : ramp_inc;
        lspd_nxt = ramp_out;
        rspd_nxt = ramp_out;
      end
      REQ_SPIN_R, REQ_SPIN_L: begin
        ldir_nxt = (s1_req_r == REQ_SPIN_R);
        rdir_nxt = !ldir_nxt;
        ramp_nxt = (ramp_r >= limit) ? ramp_r : ramp_inc;
        lspd_nxt = ramp_out;
        rspd_nxt = ramp_out;
      end
      default: begin
        ramp_nxt = '0;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r      <= '0;
      ldir_r      <= 1'b0;
      rdir_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        ramp_r <= ramp_nxt;
        ldir_r <= ldir_nxt;
        rdir_r <= rdir_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lspd_r <= lspd_nxt;
      rspd_r <= rspd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2*SPEED_W - 2){1'b0}}, rdir_r, ldir_r, rspd_r, lspd_r};

  a_stop_clears_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_req_r == REQ_STOP |=> ramp_r == '0)
    else $error("ramp not cleared after stop");

  a_reverse_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_req_r == REQ_REVERSE |=> out_tdata[2*SPEED_W] && out_tdata[2*SPEED_W+1])
    else $error("reverse did not set both directions");

  a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without output stall");

  a_ramp_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_req_r != REQ_STOP && s1_req_r <= REQ_SPIN_L |=> ramp_r >= $past(ramp_r))
    else $error("ramp decreased on a non-stop request");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for differential_drive_ramp_core: drive commands and speed
// register writes in, wheel commands checked per transaction by an in-line predictor.
// Depends on ddr_pkg and the core RTL.
module tb;
  import ddr_pkg::*;

  localparam int PIPE_DEPTH = 2;
  localparam int MAX_PRINTS = 40;
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [RUDDER_W-1:0] rudder;
    logic                slow;
  } drive_cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_spd;
    logic [SPEED_W-1:0] right_spd;
    logic               left_rev;
    logic               right_rev;
  } wheel_cmd_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SPEED_W-1:0]     cfg_data = '0;

  // predictor copy of registers and state
  logic [SPEED_W-1:0] reg_max, reg_low, reg_turn, reg_low_turn, reg_stop;
  logic [SPEED_W-1:0] ramp_lvl;
  logic               left_back, right_back;

  wheel_cmd_t wheels_due[$];
  int err_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_cnt = 0;
  int hold_until = 0;

  logic [REQ_W-1:0]     ramp_ops[4] = '{REQ_FORWARD, REQ_REVERSE, REQ_SPIN_R, REQ_SPIN_L};
  logic [REQ_W-1:0]     stop_ops[3] = '{REQ_STOP, REQ_SPARE_6, REQ_SPARE_7};
  logic [CFG_IDX_W-1:0] reg_ids[5]  = '{REG_MAX_SPEED, REG_SLOW_CAP, REG_TURN_SPEED,
                                        REG_LOW_TURN, REG_STOP_SPEED};
  logic [RUDDER_W-1:0]  rudder_marks[8] = '{8'd0, 8'd116, 8'd117, 8'd118,
                                            8'd136, 8'd137, 8'd138, 8'd255};

  differential_drive_ramp_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------- predictor ----------------
  function automatic logic [SPEED_W-1:0] limit_wheel(input logic [SPEED_W-1:0] up,
                                                     input logic [SPEED_W-1:0] lo,
                                                     input int x);
    int v;
    v = (x > 255) ? 255 : x;
    if (up <= v) return up;
    if (lo >= v) return lo;
    return v[SPEED_W-1:0];
  endfunction

  function automatic logic [SPEED_W-1:0] bump_ramp(input logic [SPEED_W-1:0] limit,
                                                   input logic [SPEED_W-1:0] cap_out);
    int nxt;
    if (ramp_lvl >= limit) return cap_out;
    nxt = ramp_lvl + 4;
    ramp_lvl = (nxt > 255) ? 8'd255 : nxt[SPEED_W-1:0];
    return ramp_lvl;
  endfunction

  function automatic wheel_cmd_t predict_wheels(input drive_cmd_t c);
    wheel_cmd_t w;
    logic [SPEED_W-1:0] s;
    int lraw, rraw;
    case (c.req)
      REQ_STEER: begin
        left_back  = 1'b0;
        right_back = 1'b0;
        if (c.slow) begin
          s = limit_wheel(reg_max, reg_low, int'(reg_low));
          w.left_spd  = s;
          w.right_spd = s;
        end else begin
          if (c.rudder > RUDDER_LO && c.rudder < RUDDER_HI) begin
            lraw = int'(reg_max);
            rraw = int'(reg_max);
          end else if (c.rudder <= RUDDER_LO) begin
            rraw = int'(reg_max);
            lraw = reg_low + (107 * c.rudder) / 117;
          end else begin
            lraw = int'(reg_max);
            rraw = (29645 - 107 * c.rudder) / 118;
          end
          w.left_spd  = limit_wheel(reg_max, reg_low, lraw);
          w.right_spd = limit_wheel(reg_max, reg_low, rraw);
        end
      end
      REQ_FORWARD, REQ_REVERSE: begin
        left_back  = (c.req == REQ_REVERSE);
        right_back = left_back;
        s = c.slow ? bump_ramp(reg_low, reg_low) : bump_ramp(reg_max, reg_max);
        w.left_spd  = s;
        w.right_spd = s;
      end
      REQ_SPIN_R, REQ_SPIN_L: begin
        left_back  = (c.req == REQ_SPIN_R);
        right_back = (c.req == REQ_SPIN_L);
        s = c.slow ? bump_ramp(reg_low, reg_low_turn) : bump_ramp(reg_turn, reg_turn);
        w.left_spd  = s;
        w.right_spd = s;
      end
      default: begin
        ramp_lvl    = '0;
        w.left_spd  = reg_stop;
        w.right_spd = reg_stop;
      end
    endcase
    w.left_rev  = left_back;
    w.right_rev = right_back;
    return w;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : result_check
    wheel_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (wheels_due.size() == 0) begin
        report_mismatch("unexpected result tdata", 32'(out_tdata), 0);
      end else begin
        want = wheels_due.pop_front();
        if (out_tdata[7:0] !== want.left_spd)
          report_mismatch("left_speed", 32'(out_tdata[7:0]), 32'(want.left_spd));
        if (out_tdata[15:8] !== want.right_spd)
          report_mismatch("right_speed", 32'(out_tdata[15:8]), 32'(want.right_spd));
        if (out_tdata[16] !== want.left_rev)
          report_mismatch("left_reverse", 32'(out_tdata[16]), 32'(want.left_rev));
        if (out_tdata[17] !== want.right_rev)
          report_mismatch("right_reverse", 32'(out_tdata[17]), 32'(want.right_rev));
        if (out_tdata[23:18] !== 6'd0)
          report_mismatch("tdata pad", 32'(out_tdata[23:18]), 0);
      end
    end
  end

  // receiver: held off while cycle_cnt < hold_until, random stalls otherwise
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt < hold_until)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ---------------- stimulus helpers ----------------
  function automatic drive_cmd_t mk_cmd(input logic [REQ_W-1:0] req,
                                        input logic [RUDDER_W-1:0] rudder,
                                        input logic slow);
    drive_cmd_t c;
    c.req    = req;
    c.rudder = rudder;
    c.slow   = slow;
    return c;
  endfunction

  task automatic send_cmd(input drive_cmd_t c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c.rudder;
    in_tuser  <= {c.slow, c.req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    wheels_due.push_back(predict_wheels(c));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (wheels_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic load_regs(input logic [SPEED_W-1:0] mx, input logic [SPEED_W-1:0] lo,
                           input logic [SPEED_W-1:0] tn, input logic [SPEED_W-1:0] lt,
                           input logic [SPEED_W-1:0] st);
    logic [SPEED_W-1:0] vals[5];
    int i;
    vals[0] = mx;
    vals[1] = lo;
    vals[2] = tn;
    vals[3] = lt;
    vals[4] = st;
    wait_drained();
    for (i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (reg_ids[i])
        REG_MAX_SPEED:  reg_max      = vals[i];
        REG_SLOW_CAP:   reg_low      = vals[i];
        REG_TURN_SPEED: reg_turn     = vals[i];
        REG_LOW_TURN:   reg_low_turn = vals[i];
        REG_STOP_SPEED: reg_stop     = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic retune_random();
    logic [SPEED_W-1:0] v[5];
    int i;
    int top;
    top = ($urandom_range(0, 9) < 4) ? 48 : 255;
    for (i = 0; i < 5; i++) v[i] = 8'($urandom_range(0, top));
    load_regs(v[0], v[1], v[2], v[3], v[4]);
  endtask

  function automatic logic [RUDDER_W-1:0] pick_rudder();
    if ($urandom_range(0, 3) == 0) return rudder_marks[3'($urandom_range(0, 7))];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly ramp runs of one mode so caps are reached; steering, stops and noise between
  task automatic send_mix(input int n_items);
    int sent;
    int pick;
    int run_len;
    int k;
    logic [REQ_W-1:0] op;
    logic slow;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        op      = ramp_ops[2'($urandom_range(0, 3))];
        slow    = 1'($urandom_range(0, 1));
        run_len = $urandom_range(1, 40);
        if (run_len > n_items - sent) run_len = n_items - sent;
        for (k = 0; k < run_len; k++)
          send_cmd(mk_cmd(op, 8'($urandom_range(0, 255)), slow));
        sent += run_len;
      end else if (pick < 78) begin
        send_cmd(mk_cmd(REQ_STEER, pick_rudder(), $urandom_range(0, 3) == 0));
        sent++;
      end else if (pick < 90) begin
        send_cmd(mk_cmd(stop_ops[2'($urandom_range(0, 2))], 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_cmd(mk_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_cmd(mk_cmd(REQ_STOP, 8'd0, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd0, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd60, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd117, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd118, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd136, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd137, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd255, 1'b0));
    send_cmd(mk_cmd(REQ_STEER, 8'd200, 1'b1));
    send_cmd(mk_cmd(REQ_FORWARD, 8'd255, 1'b0));
    send_cmd(mk_cmd(REQ_FORWARD, 8'd0, 1'b0));
    send_cmd(mk_cmd(REQ_REVERSE, 8'd170, 1'b1));
    send_cmd(mk_cmd(REQ_REVERSE, 8'd85, 1'b1));
    send_cmd(mk_cmd(REQ_STOP, 8'd255, 1'b1));
    send_cmd(mk_cmd(REQ_SPIN_R, 8'd1, 1'b0));
    send_cmd(mk_cmd(REQ_SPIN_R, 8'd2, 1'b0));
    send_cmd(mk_cmd(REQ_SPIN_L, 8'd4, 1'b1));
    send_cmd(mk_cmd(REQ_SPIN_L, 8'd8, 1'b1));
    send_cmd(mk_cmd(REQ_SPARE_6, 8'd16, 1'b0));
    send_cmd(mk_cmd(REQ_SPIN_R, 8'd32, 1'b1));
    send_cmd(mk_cmd(REQ_SPARE_7, 8'd64, 1'b1));
    send_cmd(mk_cmd(REQ_STEER, 8'd128, 1'b0));
    wait_drained();
  endtask

  task automatic test_reg_extremes();
    int k;
    load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_mix(20);
    // fast forward run with a 255 cap walks the ramp into saturation
    load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    for (k = 0; k < 70; k++) send_cmd(mk_cmd(REQ_FORWARD, 8'($urandom_range(0, 255)), 1'b0));
    send_mix(30);
    // a high slow cap pushes the steered left sum past 255
    load_regs(8'd255, 8'd200, 8'd3, 8'd0, 8'd255);
    for (k = 0; k < 30; k++) send_cmd(mk_cmd(REQ_STEER, pick_rudder(), 1'b0));
    wait_drained();
  endtask

  task automatic test_backpressure();
    load_regs(MAX_SPEED_RST, SLOW_CAP_RST, TURN_SPEED_RST, LOW_TURN_RST, 8'd9);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_until = cycle_cnt + 300;
    send_mix(40);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    retune_random();
    send_mix(n_items / 2);
    retune_random();
    send_mix(n_items - n_items / 2);
    wait_drained();
  endtask

  initial begin
    reg_max      = MAX_SPEED_RST;
    reg_low      = SLOW_CAP_RST;
    reg_turn     = TURN_SPEED_RST;
    reg_low_turn = LOW_TURN_RST;
    reg_stop     = STOP_SPEED_RST;
    ramp_lvl     = '0;
    left_back    = 1'b0;
    right_back   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_reg_extremes();
    test_backpressure();
    test_random_phase(0, 0, 185);
    test_random_phase(60, 0, 185);
    test_random_phase(0, 60, 185);
    test_random_phase(28, 28, 185);
    wait_drained();

    if (err_count == 0) begin
      $display("** differential_drive_ramp_core: PASSED **");
    end else begin
      $display("** differential_drive_ramp_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** differential_drive_ramp_core: FAILED **");
    $finish;
  end

endmodule
